// ===== src/bptc_pkg.sv =====
package bptc_pkg;

	// field widths
	localparam int RAW_W   = 24;
	localparam int CAL_W   = 16;
	localparam int PRESS_W = 17;
	localparam int TEMP_W  = 15;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// internal datapath widths
	localparam int DT_W    = 25;
	localparam int PROD_W  = 42;
	localparam int DD_W    = 50;
	localparam int Q_W     = 19;
	localparam int TEMP1_W = 20;
	localparam int TEMP2_W = 21;
	localparam int T2_W    = 17;
	localparam int AUX_W   = 34;
	localparam int FIVE_W  = 37;
	localparam int OFF_W   = 39;
	localparam int SENS_W  = 38;
	localparam int LO_W    = 19;
	localparam int MLO_W   = 45;
	localparam int MHI_W   = 44;
	localparam int FULL_W  = 63;
	localparam int DIFF_W  = 43;
	localparam int PQ_W    = 28;

	// register indexes
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_C1 = 3'd0;
	localparam reg_idx_t REG_C2 = 3'd1;
	localparam reg_idx_t REG_C3 = 3'd2;
	localparam reg_idx_t REG_C4 = 3'd3;
	localparam reg_idx_t REG_C5 = 3'd4;
	localparam reg_idx_t REG_C6 = 3'd5;

	// arithmetic constants
	localparam logic signed [TEMP1_W-1:0] TEMP_REF  = 20'sd2000;
	localparam logic signed [PROD_W-1:0]  Q_BIAS    = 42'sd8388607;
	localparam logic signed [DIFF_W-1:0]  P_BIAS    = 43'sd32767;
	localparam logic signed [TEMP2_W-1:0] TEMP_LO   = -21'sd4000;
	localparam logic signed [TEMP2_W-1:0] TEMP_HI   = 21'sd8500;
	localparam logic signed [PQ_W-1:0]    PRESS_LO  = 28'sd1000;
	localparam logic signed [PQ_W-1:0]    PRESS_HI  = 28'sd120000;

	// calibration words
	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} cal_t;

	// record handed from the temperature path to the pressure path
	typedef struct packed {
		logic                      valid;
		logic [RAW_W-1:0]          d1;
		logic signed [OFF_W-1:0]   off;
		logic signed [SENS_W-1:0]  sens;
		logic signed [TEMP_W-1:0]  temperature;
	} comp_t;

endpackage

// ===== src/bptc_if.sv =====
interface bptc_in_if;
	import bptc_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;
	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bptc_out_if;
	import bptc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [PRESS_W-1:0]       pressure;
	logic signed [TEMP_W-1:0] temperature;
	modport source (output valid, output pressure, output temperature, input ready);
	modport sink (input valid, input pressure, input temperature, output ready);
endinterface

// ===== src/bptc_apb_regs.sv =====
module bptc_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bptc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bptc_pkg::DATA_W-1:0]   pwdata,
	output logic [bptc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output bptc_pkg::cal_t                cal
);
	import bptc_pkg::*;

	cal_t     cal_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cal    = cal_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_C1: begin
					cal_q.c1 <= pwdata[CAL_W-1:0];
				end
				REG_C2: begin
					cal_q.c2 <= pwdata[CAL_W-1:0];
				end
				REG_C3: begin
					cal_q.c3 <= pwdata[CAL_W-1:0];
				end
				REG_C4: begin
					cal_q.c4 <= pwdata[CAL_W-1:0];
				end
				REG_C5: begin
					cal_q.c5 <= pwdata[CAL_W-1:0];
				end
				REG_C6: begin
					cal_q.c6 <= pwdata[CAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_C1:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.c1};
			REG_C2:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.c2};
			REG_C3:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.c3};
			REG_C4:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.c4};
			REG_C5:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.c5};
			REG_C6:  prdata = {{(DATA_W-CAL_W){1'b0}}, cal_q.c6};
			default: prdata = '0;
		endcase
	end

endmodule

// ===== src/bptc_temp_path.sv =====
module bptc_temp_path (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [bptc_pkg::RAW_W-1:0]   raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]   raw_temperature,
	input  bptc_pkg::cal_t               cal,
	output bptc_pkg::comp_t              comp
);
	import bptc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [RAW_W-1:0] d1_s1, d1_s2, d1_s3, d1_s4, d1_s5;

	logic signed [DT_W-1:0]    dt_s1;
	logic signed [PROD_W-1:0]  prod_t_s2, prod_off_s2, prod_sens_s2;
	logic signed [DD_W-1:0]    prod_dd_s2;
	logic signed [Q_W-1:0]     q_s3;
	logic signed [TEMP1_W-1:0] temp1_s3;
	logic signed [OFF_W-1:0]   off_s3, off_s4, off_s5;
	logic signed [SENS_W-1:0]  sens_s3, sens_s4, sens_s5;
	logic [T2_W-1:0]           t2_s3;
	logic                      low_s3, low_s4;
	logic [AUX_W-1:0]          aux_s4;
	logic signed [TEMP2_W-1:0] temp2_s4;
	logic signed [TEMP_W-1:0]  temp_s5;

	logic signed [PROD_W-1:0]   q_adj;
	logic signed [Q_W-1:0]      q;
	logic signed [OFF_W-1:0]    off_base;
	logic signed [SENS_W-1:0]   sens_base;
	logic signed [2*Q_W-1:0]    aux_full;
	logic signed [TEMP2_W-1:0]  temp1_ext;
	logic [FIVE_W-1:0]          five_aux;
	logic [OFF_W-1:0]           off_corr;
	logic [SENS_W-1:0]          sens_corr;
	logic signed [TEMP2_W-1:0]  temp_sat;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 3 logic: scale products, form temp, off and sens
	always_comb begin
		q_adj     = prod_t_s2 + (prod_t_s2[PROD_W-1] ? Q_BIAS : '0);
		q         = q_adj[PROD_W-1:23];
		off_base  = $signed({7'b0, cal.c2, 16'h0000})
			+ $signed({{4{prod_off_s2[PROD_W-1]}}, prod_off_s2[PROD_W-1:7]});
		sens_base = $signed({7'b0, cal.c1, 15'h0000})
			+ $signed({{4{prod_sens_s2[PROD_W-1]}}, prod_sens_s2[PROD_W-1:8]});
	end

	// stage 4 and 5 logic: square term, second-order corrections, clamp
	always_comb begin
		aux_full  = q_s3 * q_s3;
		temp1_ext = {temp1_s3[TEMP1_W-1], temp1_s3};
		five_aux  = {1'b0, aux_s4, 2'b00} + {3'b000, aux_s4};
		off_corr  = low_s4 ? {3'b000, five_aux[FIVE_W-1:1]} : '0;
		sens_corr = low_s4 ? {3'b000, five_aux[FIVE_W-1:2]} : '0;
		if (temp2_s4 < TEMP_LO) begin
			temp_sat = TEMP_LO;
		end else if (temp2_s4 > TEMP_HI) begin
			temp_sat = TEMP_HI;
		end else begin
			temp_sat = temp2_s4;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: temperature difference
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});
			// stage 2: products of dt
			d1_s2        <= d1_s1;
			prod_t_s2    <= dt_s1 * $signed({1'b0, cal.c6});
			prod_off_s2  <= dt_s1 * $signed({1'b0, cal.c4});
			prod_sens_s2 <= dt_s1 * $signed({1'b0, cal.c3});
			prod_dd_s2   <= dt_s1 * dt_s1;
			// stage 3: first-order results
			d1_s3    <= d1_s2;
			q_s3     <= q;
			temp1_s3 <= TEMP_REF + {q[Q_W-1], q};
			off_s3   <= off_base;
			sens_s3  <= sens_base;
			t2_s3    <= prod_dd_s2[47:31];
			low_s3   <= q[Q_W-1];
			// stage 4: square of the deviation, corrected temperature
			d1_s4    <= d1_s3;
			aux_s4   <= aux_full[AUX_W-1:0];
			temp2_s4 <= low_s3 ? temp1_ext - $signed({4'b0000, t2_s3}) : temp1_ext;
			off_s4   <= off_s3;
			sens_s4  <= sens_s3;
			low_s4   <= low_s3;
			// stage 5: corrected offset and sensitivity, clamped temperature
			d1_s5   <= d1_s4;
			off_s5  <= off_s4 - $signed(off_corr);
			sens_s5 <= sens_s4 - $signed(sens_corr);
			temp_s5 <= temp_sat[TEMP_W-1:0];
		end
	end

	assign comp.valid       = v_s5;
	assign comp.d1          = d1_s5;
	assign comp.off         = off_s5;
	assign comp.sens        = sens_s5;
	assign comp.temperature = temp_s5;

endmodule

// ===== src/bptc_press_path.sv =====
module bptc_press_path (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  bptc_pkg::comp_t                    comp,
	output logic                               out_valid,
	output logic [bptc_pkg::PRESS_W-1:0]       pressure,
	output logic signed [bptc_pkg::TEMP_W-1:0] temperature
);
	import bptc_pkg::*;

	logic v_s6, v_s7, out_valid_q;

	logic [MLO_W-1:0]         mul_lo_s6;
	logic signed [MHI_W-1:0]  mul_hi_s6;
	logic signed [OFF_W-1:0]  off_s6;
	logic signed [TEMP_W-1:0] temp_s6, temp_s7;
	logic signed [DIFF_W-1:0] diff_s7;
	logic [PRESS_W-1:0]       pressure_q;
	logic signed [TEMP_W-1:0] temperature_q;

	logic signed [FULL_W-1:0] full;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] p_adj;
	logic signed [PQ_W-1:0]   p_q;
	logic signed [PQ_W-1:0]   p_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s6        <= comp.valid;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	// stage 7 logic: join partial products, scale, remove offset
	always_comb begin
		full = $signed({mul_hi_s6, 19'b0}) + $signed({18'b0, mul_lo_s6});
		diff = $signed({full[FULL_W-1], full[FULL_W-1:21]})
			- $signed({{4{off_s6[OFF_W-1]}}, off_s6});
	end

	// output stage logic: divide toward zero, clamp
	always_comb begin
		p_adj = diff_s7 + (diff_s7[DIFF_W-1] ? P_BIAS : '0);
		p_q   = p_adj[DIFF_W-1:15];
		if (p_q < PRESS_LO) begin
			p_sat = PRESS_LO;
		end else if (p_q > PRESS_HI) begin
			p_sat = PRESS_HI;
		end else begin
			p_sat = p_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 6: d1 times sens, split in two partial products
			mul_lo_s6 <= $signed({1'b0, comp.d1}) * $signed({1'b0, comp.sens[LO_W-1:0]});
			mul_hi_s6 <= $signed({1'b0, comp.d1}) * $signed(comp.sens[SENS_W-1:LO_W]);
			off_s6    <= comp.off;
			temp_s6   <= comp.temperature;
			// stage 7
			diff_s7 <= diff;
			temp_s7 <= temp_s6;
			// output register
			pressure_q    <= p_sat[PRESS_W-1:0];
			temperature_q <= temp_s7;
		end
	end

	assign out_valid   = out_valid_q;
	assign pressure    = pressure_q;
	assign temperature = temperature_q;

endmodule

// ===== src/baro_pressure_temp_compensation_top.sv =====
// Barometric pressure and temperature compensation.
// Input channel "sample" carries one raw pressure and one raw temperature
// conversion result per transaction; output channel "result" carries the
// compensated pressure (0.01 mbar, clamped to 1000..120000) and
// temperature (0.01 degC, clamped to -4000..8500) for each one, in order.
// The six calibration words are written over the APB port at byte
// addresses 0, 4, .. 20; they should be loaded while no transaction is
// in flight.
// The datapath is an eight-stage pipeline; unless the receiver holds a
// result back, a new sample can be accepted every cycle. The 25x25 dt
// square and the d1 times sensitivity product, split in two partial
// products, set the stage boundaries.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and sample.ready drops; nothing is lost or repeated.
// Reset clears the calibration words to zero and empties the pipeline.
module baro_pressure_temp_compensation_top (
	input  logic                          clk,
	input  logic                          arst_n,
	bptc_in_if.sink                       sample,
	bptc_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bptc_pkg::ADDR_W-1:0]   paddr,
	input  logic [bptc_pkg::DATA_W-1:0]   pwdata,
	output logic [bptc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import bptc_pkg::*;

	cal_t  cal;
	comp_t comp;
	logic  en;
	logic  out_valid;

	// pipeline advances unless a result is held by the receiver
	assign en           = !out_valid || result.ready;
	assign sample.ready = en;
	assign result.valid = out_valid;

	bptc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	bptc_temp_path u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (sample.valid),
		.raw_pressure    (sample.raw_pressure),
		.raw_temperature (sample.raw_temperature),
		.cal             (cal),
		.comp            (comp)
	);

	bptc_press_path u_press (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.comp        (comp),
		.out_valid   (out_valid),
		.pressure    (result.pressure),
		.temperature (result.temperature)
	);

endmodule

// ===== tb/sv/bptc_comp_checker.sv =====
`timescale 1ns / 1ps

module bptc_comp_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	bptc_in_if                          sample,
	bptc_out_if                         result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [bptc_pkg::ADDR_W-1:0] paddr,
	input  logic [bptc_pkg::DATA_W-1:0] pwdata,
	input  logic [bptc_pkg::DATA_W-1:0] prdata,
	output int                          fail_count,
	output int                          pending
);
	import bptc_pkg::*;

	localparam longint REF_CENTI   = 2000;
	localparam longint TEMP_SCALE  = 8388608;
	localparam longint PRESS_SCALE = 32768;
	localparam longint SECOND_K    = 5;
	localparam longint PRESS_MIN   = 1000;
	localparam longint PRESS_MAX   = 120000;
	localparam longint TEMP_MIN    = -4000;
	localparam longint TEMP_MAX    = 8500;

	typedef struct packed {
		logic [PRESS_W-1:0]       pressure;
		logic signed [TEMP_W-1:0] temperature;
	} reading_t;

	cal_t     cal_words;
	reading_t expected_readings[$];
	reading_t due;
	reg_idx_t idx;

	function automatic logic [CAL_W-1:0] word_at(input reg_idx_t r);
		case (r)
			REG_C1:  return cal_words.c1;
			REG_C2:  return cal_words.c2;
			REG_C3:  return cal_words.c3;
			REG_C4:  return cal_words.c4;
			REG_C5:  return cal_words.c5;
			REG_C6:  return cal_words.c6;
			default: return '0;
		endcase
	endfunction

	// compensated pressure and temperature for one pair of raw readings
	function automatic reading_t compensate(input logic [RAW_W-1:0] raw_p,
			input logic [RAW_W-1:0] raw_t);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, temp, off, sens, p, t2, aux;
		reading_t r;
		d1 = raw_p;
		d2 = raw_t;
		c1 = cal_words.c1;
		c2 = cal_words.c2;
		c3 = cal_words.c3;
		c4 = cal_words.c4;
		c5 = cal_words.c5;
		c6 = cal_words.c6;

		// first-order terms
		dt   = d2 - c5 * 256;
		temp = REF_CENTI + (dt * c6) / TEMP_SCALE;
		off  = c2 * 65536 + ((c4 * dt) >>> 7);
		sens = c1 * 32768 + ((c3 * dt) >>> 8);

		// second-order correction below 20 degrees, off and sens from the uncorrected temp
		if (temp < REF_CENTI) begin
			t2   = (dt * dt) >>> 31;
			aux  = (temp - REF_CENTI) * (temp - REF_CENTI);
			off  = off - ((SECOND_K * aux) >>> 1);
			sens = sens - ((SECOND_K * aux) >>> 2);
			temp = temp - t2;
		end

		p = (((d1 * sens) >>> 21) - off) / PRESS_SCALE;

		// saturate both outputs
		if (p < PRESS_MIN)
			p = PRESS_MIN;
		else if (p > PRESS_MAX)
			p = PRESS_MAX;
		if (temp < TEMP_MIN)
			temp = TEMP_MIN;
		else if (temp > TEMP_MAX)
			temp = TEMP_MAX;

		r.pressure    = p[PRESS_W-1:0];
		r.temperature = temp[TEMP_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_words = '0;
			expected_readings.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			idx = paddr[ADDR_W-1:2];

			// calibration word writes, unmapped indexes ignored
			if (psel && penable && pwrite && pready) begin
				case (idx)
					REG_C1:  cal_words.c1 = pwdata[CAL_W-1:0];
					REG_C2:  cal_words.c2 = pwdata[CAL_W-1:0];
					REG_C3:  cal_words.c3 = pwdata[CAL_W-1:0];
					REG_C4:  cal_words.c4 = pwdata[CAL_W-1:0];
					REG_C5:  cal_words.c5 = pwdata[CAL_W-1:0];
					REG_C6:  cal_words.c6 = pwdata[CAL_W-1:0];
					default: ;
				endcase
			end

			// readback of mapped registers
			if (psel && penable && !pwrite && pready && idx <= REG_C6) begin
				if (prdata !== DATA_W'(word_at(idx))) begin
					$error("prdata of register %0d: expected %0h, got %0h",
						idx, word_at(idx), prdata);
					fail_count++;
				end
			end

			// accepted sample transaction
			if (sample.valid && sample.ready)
				expected_readings.push_back(compensate(sample.raw_pressure,
					sample.raw_temperature));

			// accepted result transaction
			if (result.valid && result.ready) begin
				if (expected_readings.size() == 0) begin
					$error("result with nothing expected: pressure %0d, temperature %0d",
						result.pressure, result.temperature);
					fail_count++;
				end else begin
					due = expected_readings.pop_front();
					if (result.pressure !== due.pressure) begin
						$error("pressure: expected %0d, got %0d",
							due.pressure, result.pressure);
						fail_count++;
					end
					if (result.temperature !== due.temperature) begin
						$error("temperature: expected %0d, got %0d",
							due.temperature, result.temperature);
						fail_count++;
					end
				end
			end

			pending <= expected_readings.size();
		end
	end

endmodule

// ===== tb/sv/baro_pressure_temp_compensation_top_test.sv =====
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_top_test;
	import bptc_pkg::*;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	localparam int RESET_CYCLES = 6;
	localparam int BUSY_PCT     = 70;
	localparam int BOTH_PCT     = 31;
	localparam int PHASE_ITEMS  = 215;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT  = 3000;
	localparam int TYPICAL_D1   = 9085466;
	localparam int TYPICAL_D2   = 8569150;
	localparam int COLD_SCALE   = 8388608;

	localparam logic [RAW_W-1:0] RAW_MAX = '1;
	localparam reg_idx_t UNMAPPED_IDX = 3'd6;
	localparam cal_t TYPICAL_CAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
		c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;
	int                idle_pct = 0;
	int                stall_pct = 0;
	bit                hold_arm = 1'b0;
	bit                held = 1'b0;
	int                hold_left = 0;
	int                quiet = 0;

	bptc_in_if  sample_ch();
	bptc_out_if result_ch();

	baro_pressure_temp_compensation_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bptc_comp_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.result     (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 100 MHz clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result receiver: random stalls, one long hold-off when armed
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_arm && !held) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (psel && penable)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// one raw reading pair, with a random idle gap first
	task automatic send_sample(input logic [RAW_W-1:0] press_raw,
			input logic [RAW_W-1:0] temp_raw);
		while ($urandom_range(99) < idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.raw_pressure <= press_raw;
		sample_ch.raw_temperature <= temp_raw;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// stop sending and let every expected result come out
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input reg_idx_t r, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {r, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write all calibration words, poke an unmapped address, read the calibration words back
	task automatic load_cal(input cal_t c);
		apb_access(1'b1, REG_C1, {16'($urandom()), c.c1});
		apb_access(1'b1, REG_C2, {16'($urandom()), c.c2});
		apb_access(1'b1, REG_C3, {16'($urandom()), c.c3});
		apb_access(1'b1, REG_C4, {16'($urandom()), c.c4});
		apb_access(1'b1, REG_C5, {16'($urandom()), c.c5});
		apb_access(1'b1, REG_C6, {16'($urandom()), c.c6});
		apb_access(1'b1, UNMAPPED_IDX, $urandom());
		for (reg_idx_t r = REG_C1; r <= REG_C6; r++)
			apb_access(1'b0, r, '0);
	endtask

	function automatic cal_t random_cal();
		return {$urandom(), $urandom(), $urandom()};
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw_pressure();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return RAW_W'($urandom());
		if (sel < 9)
			return RAW_W'(TYPICAL_D1 + int'($urandom_range(2097152)) - 1048576);
		return $urandom_range(1) ? RAW_MAX : RAW_W'(0);
	endfunction

	// full range, near the reference temperature, cold side, or extremes
	function automatic logic [RAW_W-1:0] pick_raw_temp(input cal_t c);
		int sel;
		int base;
		int t;
		base = int'(c.c5) * 256;
		sel = $urandom_range(9);
		if (sel < 4)
			return RAW_W'($urandom());
		if (sel == 9)
			return $urandom_range(1) ? RAW_MAX : RAW_W'(0);
		if (sel < 7)
			t = base + int'($urandom_range(131070)) - 65535;
		else
			t = base - int'($urandom_range(4194304));
		if (t < 0)
			t = 0;
		if (t > int'(RAW_MAX))
			t = int'(RAW_MAX);
		return RAW_W'(t);
	endfunction

	task automatic run_phase(input cal_t c, input idle_mode_t mode, input bit hold,
			input bit pause);
		wait_drained();
		load_cal(c);
		case (mode)
			IDLE_NONE: begin idle_pct = 0; stall_pct = 0; end
			IDLE_SEND: begin idle_pct = BUSY_PCT; stall_pct = 0; end
			IDLE_RECV: begin idle_pct = 0; stall_pct = BUSY_PCT; end
			IDLE_BOTH: begin idle_pct = BOTH_PCT; stall_pct = BOTH_PCT; end
			default: begin idle_pct = 0; stall_pct = 0; end
		endcase
		hold_arm = hold;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (pause && n == PHASE_ITEMS / 2)
				wait_drained();
			send_sample(pick_raw_pressure(), pick_raw_temp(c));
		end
		hold_arm = 1'b0;
	endtask

	initial begin
		int ref_t;
		int cold;
		logic [5:0] m;
		cal_t mix;

		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_pressure = '0;
		sample_ch.raw_temperature = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners with the calibration words at reset
		send_sample(RAW_W'(0), RAW_W'(0));
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(RAW_W'(0), RAW_MAX);
		send_sample(RAW_MAX, RAW_W'(0));

		// directed items on typical calibration
		wait_drained();
		load_cal(TYPICAL_CAL);
		ref_t = int'(TYPICAL_CAL.c5) * 256;
		cold = (COLD_SCALE + int'(TYPICAL_CAL.c6) - 1) / int'(TYPICAL_CAL.c6);
		send_sample(RAW_W'(TYPICAL_D1), RAW_W'(TYPICAL_D2));
		send_sample(RAW_W'(0), RAW_W'(0));
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(RAW_W'(0), RAW_MAX);
		send_sample(RAW_MAX, RAW_W'(0));
		// dt zero, and the edges of the low-temperature branch
		send_sample(RAW_W'(TYPICAL_D1), RAW_W'(ref_t));
		send_sample(RAW_W'(TYPICAL_D1), RAW_W'(ref_t - 1));
		send_sample(RAW_W'(TYPICAL_D1), RAW_W'(ref_t - cold + 1));
		send_sample(RAW_W'(TYPICAL_D1), RAW_W'(ref_t - cold));
		send_sample(RAW_MAX, RAW_W'(ref_t - cold));
		send_sample(RAW_W'(0), RAW_W'(ref_t - cold));
		send_sample(RAW_W'(TYPICAL_D1), RAW_W'(ref_t + 1));
		send_sample(24'h800000, 24'h7fffff);
		send_sample(24'h555555, 24'haaaaaa);
		send_sample(24'haaaaaa, 24'h555555);
		send_sample(RAW_W'(1), RAW_W'(1));

		// random phases over several calibrations and flow patterns
		m = 6'($urandom_range(62) + 1);
		mix = {{16{m[5]}}, {16{m[4]}}, {16{m[3]}}, {16{m[2]}}, {16{m[1]}}, {16{m[0]}}};
		run_phase(TYPICAL_CAL, IDLE_NONE, 1'b0, 1'b0);
		run_phase('1, IDLE_SEND, 1'b0, 1'b0);
		run_phase(random_cal(), IDLE_RECV, 1'b0, 1'b0);
		run_phase(random_cal(), IDLE_NONE, 1'b1, 1'b0);
		run_phase('0, IDLE_BOTH, 1'b0, 1'b0);
		run_phase(mix, IDLE_BOTH, 1'b0, 1'b1);
		run_phase(random_cal(), IDLE_SEND, 1'b0, 1'b0);

		wait_drained();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bptc_pkg.sv
src/bptc_if.sv
src/bptc_apb_regs.sv
src/bptc_temp_path.sv
src/bptc_press_path.sv
src/baro_pressure_temp_compensation_top.sv
tb/sv/bptc_comp_checker.sv
tb/sv/baro_pressure_temp_compensation_top_test.sv
